[src/isc_pkg.sv]
// Shared constants, types and codes of the interval set coalescer.
package isc_pkg;

  localparam int MAX_INTERVALS = 32;
  localparam int VALUE_BITS    = 16;
  localparam int IDX_BITS      = $clog2(MAX_INTERVALS);
  localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_DUMP = 1'b1;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_DUP   = 3'd1,
    ST_FULL  = 3'd2,
    ST_RANGE = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // One table entry: closed interval [lo, hi]
  typedef struct packed {
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
  } entry_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic lo_le;    // entry.lo <= value
    logic hi_ge;    // entry.hi >= value
    logic touch_l;  // left hi + 1 == value
    logic touch_r;  // value + 1 == entry.lo
  } cmp_t;

endpackage

[src/isc_table_ram.sv]
// Interval table memory: one write port, one registered read port.
module isc_table_ram import isc_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_BITS-1:0] wr_addr,
  input  entry_t              wr_data,
  input  logic [IDX_BITS-1:0] rd_addr,
  output entry_t              rd_data
);

  entry_t mem [MAX_INTERVALS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/isc_cmp.sv]
// Shared compare unit: value against one entry and the saved left neighbor.
module isc_cmp import isc_pkg::*; (
  input  logic [VALUE_BITS-1:0] v,
  input  entry_t                entry,
  input  logic [VALUE_BITS-1:0] left_hi,
  output cmp_t                  flags
);

  // one extra bit so the top value does not wrap
  logic [VALUE_BITS:0] v_inc;
  logic [VALUE_BITS:0] left_inc;

  assign v_inc    = {1'b0, v} + {{VALUE_BITS{1'b0}}, 1'b1};
  assign left_inc = {1'b0, left_hi} + {{VALUE_BITS{1'b0}}, 1'b1};

  assign flags.lo_le   = (entry.lo <= v);
  assign flags.hi_ge   = (entry.hi >= v);
  assign flags.touch_l = (left_inc == {1'b0, v});
  assign flags.touch_r = (v_inc == {1'b0, entry.lo});

endmodule

[src/interval_set_coalescer.sv]
// Interval set coalescer top level: sequencer over the interval table.
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  input   | in_valid / in_stall | cmd, value
//  output  | out_valid/out_stall | status, range_start, range_end, last
//
// An add: accept, then a search that steps past intervals with one RAM read each,
// then a result; a bridge first moves the entries above it down one place, a new
// interval below the top moves the entries above it up and ends with one insert write.
// A dump emits one range per interval, an empty dump a single EMPTY status.
// in_stall is high whenever a request is in progress; output stalls hold the
// sequencer. Reset (rst, synchronous) empties the table by clearing the count.
module interval_set_coalescer import isc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  cmd,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [VALUE_BITS-1:0] range_start,
  output logic [VALUE_BITS-1:0] range_end,
  output logic                  last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SHDN,
    S_SHUP,
    S_INS,
    S_EMIT,
    S_DUMP
  } state_t;

  localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0] CNT_TWO = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_INTERVALS);

  state_t                state, state_next;
  logic [CNT_BITS-1:0]   idx, idx_next;
  logic [CNT_BITS-1:0]   count, count_next;
  logic [CNT_BITS-1:0]   pos, pos_next;
  logic [VALUE_BITS-1:0] v, v_next;
  logic [VALUE_BITS-1:0] left_lo, left_lo_next;
  logic [VALUE_BITS-1:0] left_hi, left_hi_next;
  status_t               res, res_next;
  status_t               status_q;

  // RAM port and compare unit signals
  logic                  we;
  logic [IDX_BITS-1:0]   wr_addr;
  entry_t                wr_data;
  logic [IDX_BITS-1:0]   rd_addr;
  entry_t                rd_data;
  cmp_t                  flags;

  // emit controls for the output register
  logic                  emit;
  status_t               emit_status;
  logic [VALUE_BITS-1:0] emit_lo;
  logic [VALUE_BITS-1:0] emit_hi;
  logic                  emit_last;

  logic                  out_free;
  logic [CNT_BITS-1:0]   idx_inc;
  logic [CNT_BITS-1:0]   idx_inc2;
  logic [CNT_BITS-1:0]   idx_dec;
  logic [CNT_BITS-1:0]   idx_dec2;
  logic [CNT_BITS-1:0]   count_dec;
  logic                  has_left;
  logic                  has_right;
  logic                  tl;
  logic                  tr;

  isc_table_ram u_ram (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  isc_cmp u_cmp (
    .v       (v),
    .entry   (rd_data),
    .left_hi (left_hi),
    .flags   (flags)
  );

  assign in_stall    = (state != S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign status      = status_q;

  assign idx_inc   = idx + CNT_ONE;
  assign idx_inc2  = idx + CNT_TWO;
  assign idx_dec   = idx - CNT_ONE;
  assign idx_dec2  = idx - CNT_TWO;
  assign count_dec = count - CNT_ONE;
  assign has_left  = (idx != '0);
  assign has_right = (idx < count);
  assign tl        = has_left && flags.touch_l;
  assign tr        = has_right && flags.touch_r;

  // sequencer: next state, RAM accesses and emits
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    count_next   = count;
    pos_next     = pos;
    v_next       = v;
    left_lo_next = left_lo;
    left_hi_next = left_hi;
    res_next     = res;
    rd_addr      = idx[IDX_BITS-1:0];
    we           = 1'b0;
    wr_addr      = idx[IDX_BITS-1:0];
    wr_data      = '{lo: v, hi: v};
    emit         = 1'b0;
    emit_status  = res;
    emit_lo      = '0;
    emit_hi      = '0;
    emit_last    = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_ADD) begin
            v_next     = value;
            idx_next   = '0;
            rd_addr    = '0;
            state_next = S_SRCH;
          end else if (count == '0) begin
            res_next   = ST_EMPTY;
            state_next = S_EMIT;
          end else begin
            idx_next   = '0;
            rd_addr    = '0;
            state_next = S_DUMP;
          end
        end
      end

      // walk entries while entry.lo <= value; rd_data is entry idx
      S_SRCH: begin
        if (has_right && flags.lo_le) begin
          if (flags.hi_ge) begin
            res_next   = ST_DUP;
            state_next = S_EMIT;
          end else begin
            left_lo_next = rd_data.lo;
            left_hi_next = rd_data.hi;
            idx_next     = idx_inc;
            rd_addr      = idx_inc[IDX_BITS-1:0];
          end
        end else if (tl && tr) begin
          // bridge: left takes right's end, entries above close the gap
          we       = 1'b1;
          wr_addr  = idx_dec[IDX_BITS-1:0];
          wr_data  = '{lo: left_lo, hi: rd_data.hi};
          res_next = ST_ADDED;
          if (idx_inc < count) begin
            rd_addr    = idx_inc[IDX_BITS-1:0];
            state_next = S_SHDN;
          end else begin
            count_next = count_dec;
            state_next = S_EMIT;
          end
        end else if (tl) begin
          we         = 1'b1;
          wr_addr    = idx_dec[IDX_BITS-1:0];
          wr_data    = '{lo: left_lo, hi: v};
          res_next   = ST_ADDED;
          state_next = S_EMIT;
        end else if (tr) begin
          we         = 1'b1;
          wr_data    = '{lo: v, hi: rd_data.hi};
          res_next   = ST_ADDED;
          state_next = S_EMIT;
        end else if (count == CNT_MAX) begin
          res_next   = ST_FULL;
          state_next = S_EMIT;
        end else if (!has_right) begin
          // new interval at the top, no shift
          we         = 1'b1;
          count_next = count + CNT_ONE;
          res_next   = ST_ADDED;
          state_next = S_EMIT;
        end else begin
          // open a gap at idx, moving entries up from the top
          pos_next   = idx;
          idx_next   = count;
          rd_addr    = count_dec[IDX_BITS-1:0];
          state_next = S_SHUP;
        end
      end

      // rd_data is entry idx + 1, written to idx
      S_SHDN: begin
        we      = 1'b1;
        wr_data = rd_data;
        if (idx_inc2 < count) begin
          rd_addr  = idx_inc2[IDX_BITS-1:0];
          idx_next = idx_inc;
        end else begin
          count_next = count_dec;
          state_next = S_EMIT;
        end
      end

      // rd_data is entry idx - 1, written to idx
      S_SHUP: begin
        we      = 1'b1;
        wr_data = rd_data;
        if (idx_dec > pos) begin
          rd_addr  = idx_dec2[IDX_BITS-1:0];
          idx_next = idx_dec;
        end else begin
          state_next = S_INS;
        end
      end

      S_INS: begin
        we         = 1'b1;
        wr_addr    = pos[IDX_BITS-1:0];
        count_next = count + CNT_ONE;
        res_next   = ST_ADDED;
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end

      // rd_data is entry idx; address holds while the output stalls
      S_DUMP: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_status = ST_RANGE;
          emit_lo     = rd_data.lo;
          emit_hi     = rd_data.hi;
          emit_last   = (idx_inc == count);
          if (idx_inc == count) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx_inc;
            rd_addr  = idx_inc[IDX_BITS-1:0];
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      count   <= count_next;
      pos     <= pos_next;
      v       <= v_next;
      left_lo <= left_lo_next;
      left_hi <= left_hi_next;
      res     <= res_next;
      if (emit) begin
        out_valid   <= 1'b1;
        status_q    <= emit_status;
        range_start <= emit_lo;
        range_end   <= emit_hi;
        last        <= emit_last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[tb/interval_set_coalescer_test.sv]
// Self-checking testbench for the interval set coalescer: directed table, then random requests.
`timescale 1ns / 100ps

module interval_set_coalescer_test;
  import isc_pkg::*;

  localparam int RANDOM_REQUESTS = 387;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int SETTLE_CYCLES   = 80;

  // One output beat as the block should report it
  typedef struct {
    status_t               status;
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    logic                  last;
  } report_t;

  // One row of the directed plan; known marks a row whose report is typed in
  typedef struct {
    logic                  cmd;
    logic [VALUE_BITS-1:0] value;
    bit                    known;
    status_t               status;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  cmd = CMD_ADD;
  logic [VALUE_BITS-1:0] value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            status;
  logic [VALUE_BITS-1:0] range_start;
  logic [VALUE_BITS-1:0] range_end;
  logic                  last;

  // Shadow copy of the interval list
  entry_t spans [MAX_INTERVALS];
  int     span_count = 0;

  report_t due_reports [$];
  int      errors = 0;
  bit      in_busy = 1'b0;
  bit      out_busy = 1'b0;
  logic [VALUE_BITS-1:0] window_base = '0;

  plan_row_t plan [23] = '{
    '{CMD_DUMP, 16'h0000, 1'b1, ST_EMPTY},
    '{CMD_ADD,  16'h0000, 1'b1, ST_ADDED},
    '{CMD_ADD,  16'h0000, 1'b1, ST_DUP},
    '{CMD_ADD,  16'hFFFF, 1'b1, ST_ADDED},
    '{CMD_ADD,  16'hFFFF, 1'b1, ST_DUP},
    '{CMD_ADD,  16'hFFFE, 1'b0, ST_ADDED},  // grows top interval downward
    '{CMD_ADD,  16'h0001, 1'b0, ST_ADDED},  // grows bottom interval upward
    '{CMD_ADD,  16'h0003, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h0002, 1'b0, ST_ADDED},  // bridges two intervals
    '{CMD_ADD,  16'h0005, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h0007, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h0006, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h0004, 1'b0, ST_ADDED},
    '{CMD_DUMP, 16'hFFFF, 1'b0, ST_RANGE},  // value is don't-care on dump
    '{CMD_ADD,  16'hAAAA, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h5555, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h8000, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h7FFF, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h0100, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h00FF, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'hFFFD, 1'b0, ST_ADDED},
    '{CMD_ADD,  16'h0003, 1'b0, ST_DUP},    // inside an interval
    '{CMD_DUMP, 16'h0000, 1'b0, ST_RANGE}
  };

  interval_set_coalescer dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .range_start (range_start),
    .range_end   (range_end),
    .last        (last)
  );

  always #5 clk = ~clk;

  // Append one expected beat at the tail of the queue
  function automatic void queue_report(report_t r);
    due_reports.insert(due_reports.size(), r);
  endfunction

  // Apply one accepted request to the shadow list and queue its reports
  function automatic void coalesce_and_report(logic c, logic [VALUE_BITS-1:0] v);
    int      pos;
    int      i;
    bit      has_l;
    bit      has_r;
    bit      t_l;
    bit      t_r;
    status_t st;
    if (c == CMD_DUMP) begin
      if (span_count == 0) begin
        queue_report('{ST_EMPTY, '0, '0, 1'b1});
      end else begin
        for (i = 0; i < span_count; i++)
          queue_report('{ST_RANGE, spans[i].lo, spans[i].hi, i == span_count - 1});
      end
      return;
    end
    pos = 0;
    while (pos < span_count && spans[pos].lo <= v) pos++;
    has_l = pos > 0;
    has_r = pos < span_count;
    st = ST_ADDED;
    if (has_l && spans[pos-1].hi >= v) begin
      st = ST_DUP;
    end else begin
      // 17-bit compares so the top value does not wrap
      t_l = has_l && ({1'b0, spans[pos-1].hi} + 17'd1 == {1'b0, v});
      t_r = has_r && ({1'b0, v} + 17'd1 == {1'b0, spans[pos].lo});
      if (t_l && t_r) begin
        spans[pos-1].hi = spans[pos].hi;
        for (i = pos; i + 1 < span_count; i++) spans[i] = spans[i+1];
        span_count--;
      end else if (t_l) begin
        spans[pos-1].hi = v;
      end else if (t_r) begin
        spans[pos].lo = v;
      end else if (span_count >= MAX_INTERVALS) begin
        st = ST_FULL;
      end else begin
        for (i = span_count; i > pos; i--) spans[i] = spans[i-1];
        spans[pos].lo = v;
        spans[pos].hi = v;
        span_count++;
      end
    end
    queue_report('{st, '0, '0, 1'b1});
  endfunction

  // Random add value: mostly near existing edges or packed in a window
  function automatic logic [VALUE_BITS-1:0] pick_value();
    int                    kind;
    int                    idx;
    logic [VALUE_BITS:0]   mid;
    logic [VALUE_BITS-1:0] v;
    kind = $urandom_range(0, 9);
    v = VALUE_BITS'($urandom_range(0, 65535));
    if (kind < 4 && span_count > 0) begin
      idx = $urandom_range(0, span_count - 1);
      case ($urandom_range(0, 5))
        0: v = spans[idx].lo - 1'b1;
        1: v = spans[idx].hi + 1'b1;
        2: v = spans[idx].lo;
        3: v = spans[idx].hi;
        4: v = VALUE_BITS'($urandom_range(spans[idx].lo, spans[idx].hi));
        default: begin
          if (idx + 1 < span_count)
            mid = ({1'b0, spans[idx].hi} + {1'b0, spans[idx+1].lo}) >> 1;
          else
            mid = {1'b0, spans[idx].hi} + 17'd2;
          v = mid[VALUE_BITS-1:0];
        end
      endcase
    end else if (kind < 7) begin
      // spaced values open many intervals and push the table to capacity
      v = window_base + 16'($urandom_range(0, 40) * 2);
    end else if (kind == 9) begin
      v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end
    return v;
  endfunction

  // Drive one request and wait for it to be taken
  task automatic send_request(logic c, logic [VALUE_BITS-1:0] v, bit known, status_t st);
    int gap;
    gap = in_busy ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    value    <= v;
    do @(posedge clk); while (in_stall);
    coalesce_and_report(c, v);
    if (known) begin
      void'(due_reports.pop_back());
      queue_report('{st, '0, '0, 1'b1});
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Request side: directed plan, then random requests
  initial begin : stimulus
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (n = 0; n < $size(plan); n++)
      send_request(plan[n].cmd, plan[n].value, plan[n].known, plan[n].status);
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 25 == 0) begin
        in_busy     = ($urandom_range(0, 3) == 0);
        window_base = VALUE_BITS'($urandom_range(0, 65535));
      end
      if ($urandom_range(0, 99) < 15)
        send_request(CMD_DUMP, 16'($urandom_range(0, 65535)), 1'b0, ST_RANGE);
      else
        send_request(CMD_ADD, pick_value(), 1'b0, ST_ADDED);
    end
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Result side: random stalls, compare each beat with the oldest expectation
  initial begin : drain
    int      n;
    int      beats;
    report_t want;
    beats = 0;
    wait (rst == 1'b0);
    forever begin
      if (beats % 40 == 0) out_busy = ($urandom_range(0, 3) == 0);
      n = out_busy ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      beats++;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected output, expected none, got status %0d", $time, status);
        errors++;
      end else begin
        want = due_reports.pop_front();
        check_field("status", want.status, status);
        check_field("range_start", want.lo, range_start);
        check_field("range_end", want.hi, range_end);
        check_field("last", want.last, last);
      end
    end
  end

  // Hang guard
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[interval_set_coalescer.f]
src/isc_pkg.sv
src/isc_table_ram.sv
src/isc_cmp.sv
src/interval_set_coalescer.sv
tb/interval_set_coalescer_test.sv
